// ----- src/gslt_pkg.sv -----
// ----------------------------------------------------------------------------
// gslt_pkg
// Types, constants and helper functions for the gain-scheduled LQR torque
// block: item structs, sequencer states, coefficient table and saturation.
// ----------------------------------------------------------------------------
package gslt_pkg;

    // default fixed point fraction bits
    localparam int FRAC_BITS_DEF = 16;

    // coefficient table scale (values stored in units of 1e-9)
    localparam longint unsigned NANO = 64'd1000000000;

    // gain table size: twelve gains, four cubic coefficients each
    localparam int GAIN_N = 12;
    localparam int COEF_N = 4;

    // multiplier digit size and digit count over the 40-bit multiplier operand
    localparam int DIG_W  = 8;
    localparam int DIG_N  = 5;
    localparam int MULB_W = DIG_W * DIG_N;

    // config register width
    localparam int STEP_W = 17;
    localparam int LEN_W  = 17;

    typedef struct packed {
        logic [LEN_W-1:0]   leg_len;
        logic signed [31:0] leg_angle;
        logic signed [31:0] leg_angle_rate;
        logic signed [31:0] wheel_dist;
        logic signed [31:0] wheel_speed;
        logic signed [31:0] body_pitch;
        logic signed [31:0] body_pitch_rate;
        logic signed [31:0] speed_target;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] wheel_torque_half;
        logic signed [31:0] leg_torque_half;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_DIST,
        OP_HORN,
        OP_PROD
    } t_op;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // gain polynomial coefficients in units of 1e-9, index row*4 + k
    function automatic longint coef_nano(input int idx);
        case (idx)
            0:  return -64'sd228312861924;
            1:  return  64'sd294032841402;
            2:  return -64'sd161859980835;
            3:  return -64'sd27912460773;
            4:  return -64'sd311553508161;
            5:  return  64'sd488738545500;
            6:  return -64'sd288194998275;
            7:  return  64'sd69853273202;
            8:  return -64'sd25075449471;
            9:  return  64'sd30596972048;
            10: return -64'sd27301161396;
            11: return -64'sd7411074505;
            12: return -64'sd93094903570;
            13: return  64'sd139631825127;
            14: return -64'sd79325706887;
            15: return  64'sd19035063994;
            16: return -64'sd33130941383;
            17: return  64'sd40390098330;
            18: return -64'sd17245743442;
            19: return -64'sd7362234730;
            20: return -64'sd106980642247;
            21: return  64'sd153627662687;
            22: return -64'sd82336814157;
            23: return  64'sd17788054640;
            24: return -64'sd18135634107;
            25: return  64'sd20876380804;
            26: return -64'sd9349787420;
            27: return -64'sd10083454722;
            28: return -64'sd145995128360;
            29: return  64'sd202696600748;
            30: return -64'sd104633505889;
            31: return  64'sd21734646878;
            32: return -64'sd378233687962;
            33: return  64'sd543155810338;
            34: return -64'sd291104598164;
            35: return  64'sd62890270301;
            36: return  64'sd468542266417;
            37: return -64'sd571202248474;
            38: return  64'sd243891642697;
            39: return  64'sd104117722047;
            40: return -64'sd13493839159;
            41: return  64'sd19199378906;
            42: return -64'sd10454163694;
            43: return  64'sd2479754993;
            44: return  64'sd13634104984;
            45: return -64'sd16720731026;
            46: return  64'sd7213263170;
            47: return  64'sd3112497726;
            default: return 64'sd0;
        endcase
    endfunction

    // coefficient in fixed point, rounded to nearest with ties away from zero
    function automatic logic signed [63:0] coef_q(input int idx, input int frac);
        longint          v;
        longint unsigned mag;
        longint unsigned q;
        v   = coef_nano(idx);
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q   = ((mag << frac) + NANO / 2) / NANO;
        return (v < 0) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ----- src/gain_scheduled_lqr_torque.sv -----
// ----------------------------------------------------------------------------
// gain_scheduled_lqr_torque
// Ground-phase LQR torque controller with leg-length scheduled gains.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall / i_in_data : one control tick item
//   output channel o_out_valid / i_out_stall / o_out_data : wheel and leg torque
//   config channel i_cfg_valid / o_cfg_ready / i_cfg_data : step time, Q format
// Each item runs 49 multiplies on one shared multiplier that takes one 8-bit
// digit of its second operand per cycle followed by a post step to round
// and accumulate: the distance target update, three Horner steps for each of
// twelve gains and twelve gain times error products. The input stalls from
// acceptance until the sequencer has returned to idle, so the next item is
// taken only after the previous one has been completed.
// The result sits in an output register, so a new item may be accepted while
// the previous result waits; the sequencer only holds at the end of an item
// if the output register is still full and stalled.
// Reset (synchronous, active low) clears the distance target to zero, loads
// the step time with round(2^FRAC_BITS / 1000) and empties the output.
// ----------------------------------------------------------------------------
module gain_scheduled_lqr_torque
    import gslt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [STEP_W-1:0] i_cfg_data
);

    localparam int COEF_TOT = GAIN_N * COEF_N;
    localparam logic [STEP_W-1:0] STEP_RST =
        STEP_W'(((longint'(1) << FRAC_BITS) + 500) / 1000);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // coefficient table built at elaboration
    logic signed [63:0] w_coef [COEF_TOT];
    for (genvar g = 0; g < COEF_TOT; g++) begin : g_coef
        localparam logic signed [63:0] LC = coef_q(g, FRAC_BITS);
        assign w_coef[g] = LC;
    end

    t_state r_state, n_state;
    t_op    r_op;

    logic [STEP_W-1:0]   r_step;
    logic signed [31:0]  r_dist;
    logic [LEN_W-1:0]    r_len;
    logic signed [31:0]  r_wdist;
    logic signed [31:0]  r_err [6];
    logic signed [63:0]  r_a;
    logic [MULB_W-1:0]   r_b;
    logic signed [63:0]  r_p;
    logic signed [63:0]  r_u0;
    logic signed [63:0]  r_u1;
    logic [3:0]          r_row;
    logic [1:0]          r_k;
    logic [2:0]          r_dig;
    logic                r_ov;
    t_out_item           r_out;

    logic signed [DIG_W:0]      w_digit;
    logic signed [63:0]         w_pp;
    logic signed [63:0]         w_rs;
    logic signed [63:0]         w_acc;
    logic signed [63:0]         w_dsum;
    logic signed [31:0]         w_dnew;
    logic signed [31:0]         w_gain;
    logic [2:0]                 w_col;
    logic                       w_out_free;
    logic [5:0]                 w_cidx;
    logic [5:0]                 w_cidx0;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_ov || !i_out_stall;

    // multiplier digit: top digit signed, the rest unsigned
    assign w_digit = (r_dig == 3'd0) ? $signed({r_b[MULB_W-1], r_b[MULB_W-1 -: DIG_W]})
                                     : $signed({1'b0, r_b[MULB_W-1 -: DIG_W]});
    assign w_pp    = 64'(r_a * w_digit);

    // rounded product and post-processing values
    assign w_rs   = (r_p + HALF) >>> FRAC_BITS;
    assign w_cidx = 6'({r_row, r_k});
    assign w_cidx0 = 6'({r_row, 2'd0});
    assign w_acc  = w_rs + w_coef[w_cidx];
    assign w_gain = sat32(w_acc);
    assign w_col  = 3'(r_row >> 1);
    assign w_dsum = 64'(r_dist) + w_rs;
    assign w_dnew = sat32(w_dsum);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_dig == 3'(DIG_N - 1)) n_state = S_POST;
            end
            S_POST: begin
                if (r_op == OP_PROD && r_row == 4'(GAIN_N - 1)) n_state = S_DONE;
                else n_state = S_MUL;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RST;
            r_dist <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_step <= i_cfg_data;
            if (r_state == S_POST && r_op == OP_DIST) r_dist <= w_dnew;
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // capture item, form errors, start distance target multiply
                if (i_in_valid) begin
                    r_len    <= i_in_data.leg_len;
                    r_wdist  <= i_in_data.wheel_dist;
                    r_err[0] <= sat32(-64'(i_in_data.leg_angle));
                    r_err[1] <= sat32(-64'(i_in_data.leg_angle_rate));
                    r_err[3] <= sat32(-64'(i_in_data.wheel_speed));
                    r_err[4] <= sat32(-64'(i_in_data.body_pitch));
                    r_err[5] <= sat32(-64'(i_in_data.body_pitch_rate));
                    r_a      <= 64'(i_in_data.speed_target);
                    r_b      <= MULB_W'(r_step);
                    r_p      <= '0;
                    r_dig    <= '0;
                    r_op     <= OP_DIST;
                    r_row    <= '0;
                    r_k      <= 2'd1;
                    r_u0     <= '0;
                    r_u1     <= '0;
                end
            end
            S_MUL: begin
                // one digit per cycle, most significant first
                r_p   <= (r_p <<< DIG_W) + w_pp;
                r_b   <= r_b << DIG_W;
                r_dig <= r_dig + 3'd1;
            end
            S_POST: begin
                r_p   <= '0;
                r_dig <= '0;
                case (r_op)
                    OP_DIST: begin
                        r_err[2] <= sat32(64'(w_dnew) - 64'(r_wdist));
                        r_a      <= w_coef[w_cidx0];
                        r_b      <= MULB_W'(r_len);
                        r_k      <= 2'd1;
                        r_op     <= OP_HORN;
                    end
                    OP_HORN: begin
                        if (r_k == 2'd3) begin
                            r_a  <= 64'(w_gain);
                            r_b  <= MULB_W'(r_err[w_col]);
                            r_op <= OP_PROD;
                        end else begin
                            r_a <= w_acc;
                            r_b <= MULB_W'(r_len);
                            r_k <= r_k + 2'd1;
                        end
                    end
                    OP_PROD: begin
                        if (r_row[0]) r_u1 <= r_u1 + w_rs;
                        else          r_u0 <= r_u0 + w_rs;
                        if (r_row != 4'(GAIN_N - 1)) begin
                            r_row <= r_row + 4'd1;
                            r_a   <= w_coef[6'({r_row + 4'd1, 2'd0})];
                            r_b   <= MULB_W'(r_len);
                            r_k   <= 2'd1;
                            r_op  <= OP_HORN;
                        end
                    end
                    default: r_op <= OP_DIST;
                endcase
            end
            S_DONE: begin
                // halve with rounding and saturate into the output register
                if (w_out_free) begin
                    r_out.wheel_torque_half <= sat32((r_u0 + 64'sd1) >>> 1);
                    r_out.leg_torque_half   <= sat32((64'sd1 - r_u1) >>> 1);
                end
            end
            default: r_dig <= '0;
        endcase
    end

endmodule

// ----- tb/gain_scheduled_lqr_torque_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_scheduled_lqr_torque_test
// Self-checking bench for the LQR torque block: directed ticks from a table,
// then random bursts, with a local model of the gain cubics, the distance
// target and the saturating outputs. Step time is rewritten between phases.
// ----------------------------------------------------------------------------
module gain_scheduled_lqr_torque_test;
    import gslt_pkg::*;

    localparam int FRAC = 16;
    localparam int SETTLE = 400;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd66;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [STEP_W-1:0] i_cfg_data;

    gain_scheduled_lqr_torque u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // model state and scoreboard
    longint      step_time_m;
    longint      dist_target_m;
    t_out_item   torque_q[$];
    int          errors;
    longint      cycles = 0;
    bit          hold_long;

    // fixed expectation travelling beside the offered item
    bit          in_fixed;
    t_out_item   in_want;

    // ROM coefficient in Q format, nearest with ties away from zero
    function automatic longint coef_fixed(input int row, input int k);
        longint v;
        longint unsigned mag;
        longint unsigned q;
        case (row * 4 + k)
            0:  v = -64'sd228312861924;   1:  v = 64'sd294032841402;
            2:  v = -64'sd161859980835;   3:  v = -64'sd27912460773;
            4:  v = -64'sd311553508161;   5:  v = 64'sd488738545500;
            6:  v = -64'sd288194998275;   7:  v = 64'sd69853273202;
            8:  v = -64'sd25075449471;    9:  v = 64'sd30596972048;
            10: v = -64'sd27301161396;    11: v = -64'sd7411074505;
            12: v = -64'sd93094903570;    13: v = 64'sd139631825127;
            14: v = -64'sd79325706887;    15: v = 64'sd19035063994;
            16: v = -64'sd33130941383;    17: v = 64'sd40390098330;
            18: v = -64'sd17245743442;    19: v = -64'sd7362234730;
            20: v = -64'sd106980642247;   21: v = 64'sd153627662687;
            22: v = -64'sd82336814157;    23: v = 64'sd17788054640;
            24: v = -64'sd18135634107;    25: v = 64'sd20876380804;
            26: v = -64'sd9349787420;     27: v = -64'sd10083454722;
            28: v = -64'sd145995128360;   29: v = 64'sd202696600748;
            30: v = -64'sd104633505889;   31: v = 64'sd21734646878;
            32: v = -64'sd378233687962;   33: v = 64'sd543155810338;
            34: v = -64'sd291104598164;   35: v = 64'sd62890270301;
            36: v = 64'sd468542266417;    37: v = -64'sd571202248474;
            38: v = 64'sd243891642697;    39: v = 64'sd104117722047;
            40: v = -64'sd13493839159;    41: v = 64'sd19199378906;
            42: v = -64'sd10454163694;    43: v = 64'sd2479754993;
            44: v = 64'sd13634104984;     45: v = -64'sd16720731026;
            46: v = 64'sd7213263170;      default: v = 64'sd3112497726;
        endcase
        mag = (v < 0) ? -v : v;
        q = ((mag << FRAC) + 64'd500000000) / 64'd1000000000;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // rounded arithmetic shift, ties toward plus infinity
    function automatic longint rshift_round(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // scheduled gain from the cubic in leg length
    function automatic longint sched_gain(input int row, input longint len);
        longint acc;
        acc = coef_fixed(row, 0);
        for (int k = 1; k < 4; k++)
            acc = rshift_round(acc * len, FRAC) + coef_fixed(row, k);
        return clamp32(acc);
    endfunction

    // advance the distance target and work out the two torques
    function automatic t_out_item torque_predict(input t_in_item it);
        longint len;
        longint e[6];
        longint u[2];
        t_out_item r;
        len = longint'(it.leg_len);
        dist_target_m = clamp32(dist_target_m +
            rshift_round(longint'(it.speed_target) * step_time_m, FRAC));
        e[0] = clamp32(-longint'(it.leg_angle));
        e[1] = clamp32(-longint'(it.leg_angle_rate));
        e[2] = clamp32(dist_target_m - longint'(it.wheel_dist));
        e[3] = clamp32(-longint'(it.wheel_speed));
        e[4] = clamp32(-longint'(it.body_pitch));
        e[5] = clamp32(-longint'(it.body_pitch_rate));
        for (int row = 0; row < 2; row++) begin
            u[row] = 0;
            for (int col = 0; col < 6; col++)
                u[row] += rshift_round(sched_gain(col * 2 + row, len) * e[col], FRAC);
        end
        r.wheel_torque_half = clamp32(rshift_round(u[0], 1));
        r.leg_torque_half   = clamp32(rshift_round(-u[1], 1));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // directed stimulus table; fixed expectation only where obvious
    typedef struct {
        t_in_item  it;
        bit        fixed;
        t_out_item want;
    } t_row;

    t_row rows[$];
    int n_sent;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern plus a long hold-off on request
    initial begin
        int pat;
        i_out_stall = 1'b0;
        pat = 0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1'b1;
            end else begin
                pat = (pat + 1) % 23;
                if (pat < 8)
                    i_out_stall <= 1'b0;
                else
                    i_out_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (torque_q.size() == 0) begin
                $display("unexpected torque item");
                errors++;
            end else begin
                w = torque_q.pop_front();
                if (o_out_data.wheel_torque_half !== w.wheel_torque_half)
                    report_mismatch("wheel_torque_half", o_out_data.wheel_torque_half,
                                    w.wheel_torque_half);
                if (o_out_data.leg_torque_half !== w.leg_torque_half)
                    report_mismatch("leg_torque_half", o_out_data.leg_torque_half,
                                    w.leg_torque_half);
            end
        end
    end

    // input acceptance drives the prediction; a fixed row takes the table value
    always @(posedge i_clk) begin
        t_out_item p;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            p = torque_predict(i_in_data);
            if (in_fixed)
                torque_q.push_back(in_want);
            else
                torque_q.push_back(p);
            n_sent++;
        end
    end

    function automatic t_in_item rand_tick(input bit wild);
        t_in_item t;
        t.leg_len = wild ? LEN_W'($urandom) : LEN_W'($urandom_range(6554, 26214));
        if (wild) begin
            t.leg_angle       = $urandom;
            t.leg_angle_rate  = $urandom;
            t.wheel_dist      = $urandom;
            t.wheel_speed     = $urandom;
            t.body_pitch      = $urandom;
            t.body_pitch_rate = $urandom;
            t.speed_target    = $urandom;
        end else begin
            t.leg_angle       = $signed($urandom_range(0, 65536)) - 32768;
            t.leg_angle_rate  = $signed($urandom_range(0, 262144)) - 131072;
            t.wheel_dist      = $signed($urandom_range(0, 131072)) - 65536;
            t.wheel_speed     = $signed($urandom_range(0, 131072)) - 65536;
            t.body_pitch      = $signed($urandom_range(0, 32768)) - 16384;
            t.body_pitch_rate = $signed($urandom_range(0, 131072)) - 65536;
            t.speed_target    = $signed($urandom_range(0, 131072)) - 65536;
        end
        return t;
    endfunction

    // offer one item and wait for its acceptance
    task automatic send_tick(input t_in_item t, input bit fx = 1'b0,
                             input t_out_item w = '0);
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        in_fixed   <= fx;
        in_want    <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for the block to drain, then write step time
    task automatic write_step(input logic [STEP_W-1:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (torque_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        step_time_m = longint'(v);
    endtask

    task automatic add_row(input t_in_item t, input bit fx, input t_out_item w);
        t_row r;
        r.it = t;
        r.fixed = fx;
        r.want = w;
        rows.push_back(r);
    endtask

    task automatic random_phase(input int n);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && left > 0; b++) begin
                send_tick(rand_tick($urandom_range(0, 4) == 0));
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 400));
        end
    endtask

    initial begin
        t_in_item z;
        t_out_item zero_out;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        in_fixed    = 1'b0;
        in_want     = '0;
        hold_long   = 1'b0;
        errors      = 0;
        n_sent      = 0;
        step_time_m = longint'(STEP_RESET);
        dist_target_m = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: zero state gives zero torque at any leg length
        z = '0;
        zero_out = '0;
        add_row(z, 1'b1, zero_out);
        z.leg_len = 17'h1ffff;
        add_row(z, 1'b1, zero_out);
        z.leg_len = 17'd65536;
        add_row(z, 1'b1, zero_out);
        z.leg_len = 17'd13107;
        z.leg_angle = 32'sh80000000;
        add_row(z, 1'b0, zero_out);
        z.leg_angle = 32'sh7fffffff;
        z.body_pitch = 32'sh80000000;
        add_row(z, 1'b0, zero_out);
        z = '0;
        z.leg_len = 17'h1ffff;
        z.leg_angle_rate = 32'sh80000000;
        z.wheel_speed = 32'sh7fffffff;
        z.body_pitch_rate = 32'sh80000000;
        add_row(z, 1'b0, zero_out);
        z = '0;
        z.leg_len = 17'd19661;
        z.speed_target = 32'sh7fffffff;
        for (int i = 0; i < 3; i++) add_row(z, 1'b0, zero_out);
        z.speed_target = 32'sh80000000;
        z.wheel_dist = 32'sh7fffffff;
        for (int i = 0; i < 3; i++) add_row(z, 1'b0, zero_out);
        z = '1;
        add_row(z, 1'b0, zero_out);
        z.leg_len = '0;
        z.wheel_dist = 32'sh80000000;
        add_row(z, 1'b0, zero_out);

        foreach (rows[i]) begin
            if (rows[i].fixed) begin
                send_tick(rows[i].it, 1'b1, rows[i].want);
            end else begin
                send_tick(rows[i].it);
            end
            if ($urandom_range(0, 1) == 0) idle_sender($urandom_range(1, 300));
        end

        // step time extremes and mid values between phases
        write_step(17'd65536);
        send_tick(rand_tick(1'b0));
        send_tick(rand_tick(1'b1));
        write_step(17'd0);
        random_phase(60);
        write_step(17'h1ffff);
        random_phase(40);
        write_step(17'd66);
        random_phase(150);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_long = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_long = 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++) send_tick(rand_tick(1'b0));
            end
        join
        write_step(17'd1000);
        random_phase(170);
        i_in_valid <= 1'b0;

        // drain
        while (torque_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
